// ----- hdl/raas_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, widths and divider handshake types for the range averaging block.
// No dependencies; every other file uses this package by scoped names.
package raas_pkg;

    localparam int ANCHORS = 4;   // anchors tracked, 1..8
    localparam int WINDOW  = 5;   // smoothing slots per anchor, 1..16

    localparam int IDX_W     = 8;   // anchor_id field
    localparam int BYTE_W    = 8;   // meters / centimeters fields
    localparam int CNT_W     = 8;   // sample count and refresh register
    localparam int SUM_W     = 26;  // per-anchor millimeter sum
    localparam int MM_W      = 18;  // one distance in millimeters
    localparam int OUT_ANC_W = 3;   // out_anchor field

    localparam int ANCHOR_W  = (ANCHORS > 1) ? $clog2(ANCHORS) : 1;
    localparam int WIN_IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int TOTAL_W   = MM_W + WIN_IDX_W + 1;  // ring total
    localparam int DIV_STEP_W = $clog2(SUM_W + 1);

    // total / WINDOW as (total * RECIP_K) >> RECIP_SH; exact for totals below 2**TOTAL_W
    localparam int RECIP_SH = TOTAL_W + WIN_IDX_W;
    localparam int RECIP_W  = RECIP_SH + 1;
    localparam int PROD_W   = TOTAL_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_K =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    localparam logic [SUM_W-1:0] MM_PER_METER = SUM_W'(1000);
    localparam logic [SUM_W-1:0] MM_PER_CM    = SUM_W'(10);
    localparam logic [CNT_W-1:0] REFRESH_RST  = CNT_W'(5);
    localparam logic [CNT_W-1:0] CNT_MAX      = {CNT_W{1'b1}};

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- hdl/raas_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels for range reports (in) and smoothed results (out).
// Depends on raas_pkg for field widths.
interface raas_report_if;
    logic                             valid;
    logic                             ready;
    logic [raas_pkg::IDX_W-1:0]       anchor_id;
    logic [raas_pkg::BYTE_W-1:0]      meters_part;
    logic [raas_pkg::BYTE_W-1:0]      centimeters_part;

    modport source (output valid, anchor_id, meters_part, centimeters_part,
                    input ready);
    modport sink   (input valid, anchor_id, meters_part, centimeters_part,
                    output ready);
endinterface

interface raas_result_if;
    logic                             valid;
    logic                             ready;
    logic [raas_pkg::OUT_ANC_W-1:0]   out_anchor;
    logic [raas_pkg::MM_W-1:0]        smoothed_mm;
    logic                             had_samples;
    logic                             last_of_round;

    modport source (output valid, out_anchor, smoothed_mm, had_samples, last_of_round,
                    input ready);
    modport sink   (input valid, out_anchor, smoothed_mm, had_samples, last_of_round,
                    output ready);
endinterface

// ----- hdl/raas_div.sv -----
`timescale 1ns / 1ps
// Iterative restoring divider, one quotient bit per cycle.
// Depends on raas_pkg (widths, div_req_t / div_rsp_t).
module raas_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  raas_pkg::div_req_t req,
    output raas_pkg::div_rsp_t rsp
);

    logic [raas_pkg::CNT_W-1:0]      rem_reg, rem_next;
    logic [raas_pkg::SUM_W-1:0]      q_reg, q_next;
    logic [raas_pkg::CNT_W-1:0]      dvs_reg, dvs_next;
    logic [raas_pkg::DIV_STEP_W-1:0] step_reg, step_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;

    logic [raas_pkg::CNT_W:0] trial;
    logic [raas_pkg::CNT_W:0] diff;
    logic                     fits;

    always_comb
    begin
        trial = {rem_reg, q_reg[raas_pkg::SUM_W-1]};
        fits  = trial >= {1'b0, dvs_reg};
        diff  = trial - {1'b0, dvs_reg};

        rem_next  = rem_reg;
        q_next    = q_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start)
        begin
            rem_next  = '0;
            q_next    = req.dividend;
            dvs_next  = req.divisor;
            step_next = raas_pkg::DIV_STEP_W'(raas_pkg::SUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // remainder stays below divisor, so the low CNT_W bits hold it
            rem_next  = fits ? diff[raas_pkg::CNT_W-1:0] : trial[raas_pkg::CNT_W-1:0];
            q_next    = {q_reg[raas_pkg::SUM_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == raas_pkg::DIV_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule

// ----- hdl/range_accumulate_average_smooth.sv -----
`timescale 1ns / 1ps
// Top level: per-anchor range accumulation, block mean and moving-average smoothing.
// Depends on raas_pkg, raas_if.sv (report/result channels) and raas_div.
//
//  channel   dir  handshake           payload
//  report    in   valid/ready         anchor_id[7:0] meters_part[7:0] centimeters_part[7:0]
//  result    out  valid/ready         out_anchor[2:0] smoothed_mm[17:0] had_samples last_of_round
//  cfg       in   cfg_we (no stall)   cfg_wdata[7:0] -> refresh_count
//
// A report that starts no round passes through accept, accumulate and one count
// compare per anchor. A round adds, per sampled anchor, a start step, a divide of
// sum / count on the shared divider, WINDOW ring reads, one reciprocal multiply
// for total / WINDOW and an emit step. An anchor without samples skips the
// divide and the ring and goes from its start step straight to emit. The divider
// is the limit.
// Reset is asynchronous, active low: sums, counts, rings and pointers clear at
// once and refresh_count returns to 5. report.ready is high only when idle; a
// full result register stalls the round in its emit step until it is taken.
module range_accumulate_average_smooth
(
    input  logic                       clk,
    input  logic                       rst_n,
    raas_report_if.sink                report,
    raas_result_if.source              result,
    input  logic                       cfg_we,
    input  logic [raas_pkg::CNT_W-1:0] cfg_wdata
);

    // sequencer, one-hot
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ACC   = 8'b0000_0010,  // add report into its anchor
        S_CHECK = 8'b0000_0100,  // walk counts against refresh_count
        S_MEAN  = 8'b0000_1000,  // start sum / count
        S_DIV1  = 8'b0001_0000,  // wait mean, push into ring
        S_SUM   = 8'b0010_0000,  // add up ring slots
        S_DIV2  = 8'b0100_0000,  // total / WINDOW by reciprocal multiply
        S_EMIT  = 8'b1000_0000   // hand result to output register
    } state_t;

    state_t state_reg, state_next;

    logic [raas_pkg::CNT_W-1:0]     refresh_reg;
    logic [raas_pkg::ANCHOR_W-1:0]  anc_reg, anc_next;    // anchor under work
    logic [raas_pkg::WIN_IDX_W-1:0] slot_reg, slot_next;  // ring slot during sum
    logic                           fire_reg, fire_next;
    logic [raas_pkg::ANCHOR_W-1:0]  idx_reg, idx_next;
    logic [raas_pkg::BYTE_W-1:0]    m_reg, m_next;
    logic [raas_pkg::BYTE_W-1:0]    c_reg, c_next;
    logic [raas_pkg::TOTAL_W-1:0]   total_reg, total_next;
    logic [raas_pkg::MM_W-1:0]      val_reg, val_next;
    logic                           had_reg, had_next;

    logic [raas_pkg::SUM_W-1:0]     sum_reg  [raas_pkg::ANCHORS];
    logic [raas_pkg::SUM_W-1:0]     sum_next [raas_pkg::ANCHORS];
    logic [raas_pkg::CNT_W-1:0]     cnt_reg  [raas_pkg::ANCHORS];
    logic [raas_pkg::CNT_W-1:0]     cnt_next [raas_pkg::ANCHORS];
    logic [raas_pkg::WIN_IDX_W-1:0] ptr_reg  [raas_pkg::ANCHORS];
    logic [raas_pkg::WIN_IDX_W-1:0] ptr_next [raas_pkg::ANCHORS];
    logic [raas_pkg::MM_W-1:0]      ring_reg  [raas_pkg::ANCHORS][raas_pkg::WINDOW];
    logic [raas_pkg::MM_W-1:0]      ring_next [raas_pkg::ANCHORS][raas_pkg::WINDOW];

    // result register
    logic                           res_valid_reg, res_valid_next;
    logic [raas_pkg::OUT_ANC_W-1:0] res_anchor_reg;
    logic [raas_pkg::MM_W-1:0]      res_mm_reg;
    logic                           res_had_reg;
    logic                           res_last_reg;
    logic                           res_load;

    raas_pkg::div_req_t div_req;
    raas_pkg::div_rsp_t div_rsp;

    logic                           accept;
    logic                           anc_last;
    logic                           slot_last;
    logic                           out_free;
    logic [raas_pkg::SUM_W-1:0]     inc_mm;
    logic [raas_pkg::MM_W-1:0]      quo_mm;
    logic [raas_pkg::WIN_IDX_W-1:0] wr_ptr;
    logic [raas_pkg::PROD_W-1:0]    avg_prod;   // ring total times 1/WINDOW
    logic [raas_pkg::MM_W-1:0]      avg_mm;

    raas_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign report.ready = (state_reg == S_IDLE);
    assign accept       = report.valid && report.ready;
    assign anc_last     = (anc_reg == raas_pkg::ANCHOR_W'(raas_pkg::ANCHORS - 1));
    assign slot_last    = (slot_reg == raas_pkg::WIN_IDX_W'(raas_pkg::WINDOW - 1));
    assign out_free     = !res_valid_reg || result.ready;
    assign inc_mm       = raas_pkg::SUM_W'(m_reg) * raas_pkg::MM_PER_METER
                        + raas_pkg::SUM_W'(c_reg) * raas_pkg::MM_PER_CM;
    assign quo_mm       = div_rsp.quotient[raas_pkg::MM_W-1:0];
    // pointer never passes WINDOW-1, but wrap defensively
    assign wr_ptr       = (ptr_reg[anc_reg] >= raas_pkg::WIN_IDX_W'(raas_pkg::WINDOW - 1)
                           && ptr_reg[anc_reg] != raas_pkg::WIN_IDX_W'(raas_pkg::WINDOW - 1))
                          ? '0 : ptr_reg[anc_reg];
    // truncating divide of the ring total by WINDOW
    assign avg_prod     = raas_pkg::PROD_W'(total_reg)
                        * raas_pkg::PROD_W'(raas_pkg::RECIP_K);
    assign avg_mm       = avg_prod[raas_pkg::RECIP_SH +: raas_pkg::MM_W];

    always_comb
    begin
        state_next     = state_reg;
        anc_next       = anc_reg;
        slot_next      = slot_reg;
        fire_next      = fire_reg;
        idx_next       = idx_reg;
        m_next         = m_reg;
        c_next         = c_reg;
        total_next     = total_reg;
        val_next       = val_reg;
        had_next       = had_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        ring_next      = ring_reg;
        res_valid_next = res_valid_reg;
        res_load       = 1'b0;

        div_req.start    = 1'b0;
        div_req.dividend = sum_reg[anc_reg];
        div_req.divisor  = cnt_reg[anc_reg];

        if (res_valid_reg && result.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // out-of-range anchors are dropped here
                if (accept && report.anchor_id < raas_pkg::IDX_W'(raas_pkg::ANCHORS))
                begin
                    idx_next   = report.anchor_id[raas_pkg::ANCHOR_W-1:0];
                    m_next     = report.meters_part;
                    c_next     = report.centimeters_part;
                    state_next = S_ACC;
                end
            end

            S_ACC:
            begin
                sum_next[idx_reg] = sum_reg[idx_reg] + inc_mm;
                if (cnt_reg[idx_reg] != raas_pkg::CNT_MAX)
                begin
                    cnt_next[idx_reg] = cnt_reg[idx_reg] + 1'b1;
                end
                anc_next   = '0;
                fire_next  = 1'b0;
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                fire_next = fire_reg || (cnt_reg[anc_reg] >= refresh_reg);
                if (anc_last)
                begin
                    anc_next   = '0;
                    state_next = fire_next ? S_MEAN : S_IDLE;
                end
                else
                begin
                    anc_next = anc_reg + 1'b1;
                end
            end

            S_MEAN:
            begin
                if (cnt_reg[anc_reg] == '0)
                begin
                    val_next   = '0;
                    had_next   = 1'b0;
                    state_next = S_EMIT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV1;
                end
            end

            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    // a zero mean leaves the ring untouched
                    if (quo_mm != '0)
                    begin
                        ring_next[anc_reg][wr_ptr] = quo_mm;
                        ptr_next[anc_reg] =
                            (wr_ptr == raas_pkg::WIN_IDX_W'(raas_pkg::WINDOW - 1))
                            ? '0 : wr_ptr + 1'b1;
                    end
                    slot_next  = '0;
                    total_next = '0;
                    state_next = S_SUM;
                end
            end

            S_SUM:
            begin
                total_next = total_reg
                           + raas_pkg::TOTAL_W'(ring_reg[anc_reg][slot_reg]);
                slot_next  = slot_reg + 1'b1;
                if (slot_last)
                begin
                    state_next = S_DIV2;
                end
            end

            S_DIV2:
            begin
                val_next   = avg_mm;
                had_next   = 1'b1;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    res_load       = 1'b1;
                    res_valid_next = 1'b1;
                    if (anc_last)
                    begin
                        for (int a = 0; a < raas_pkg::ANCHORS; a++)
                        begin
                            sum_next[a] = '0;
                            cnt_next[a] = '0;
                        end
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        anc_next   = anc_reg + 1'b1;
                        state_next = S_MEAN;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            refresh_reg   <= raas_pkg::REFRESH_RST;
            anc_reg       <= '0;
            slot_reg      <= '0;
            fire_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int a = 0; a < raas_pkg::ANCHORS; a++)
            begin
                sum_reg[a] <= '0;
                cnt_reg[a] <= '0;
                ptr_reg[a] <= '0;
                for (int k = 0; k < raas_pkg::WINDOW; k++)
                begin
                    ring_reg[a][k] <= '0;
                end
            end
        end
        else
        begin
            state_reg     <= state_next;
            anc_reg       <= anc_next;
            slot_reg      <= slot_next;
            fire_reg      <= fire_next;
            res_valid_reg <= res_valid_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            ptr_reg       <= ptr_next;
            ring_reg      <= ring_next;
            if (cfg_we)
            begin
                refresh_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        m_reg     <= m_next;
        c_reg     <= c_next;
        total_reg <= total_next;
        val_reg   <= val_next;
        had_reg   <= had_next;
        if (res_load)
        begin
            res_anchor_reg <= raas_pkg::OUT_ANC_W'(anc_reg);
            res_mm_reg     <= val_reg;
            res_had_reg    <= had_reg;
            res_last_reg   <= anc_last;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.out_anchor    = res_anchor_reg;
    assign result.smoothed_mm   = res_mm_reg;
    assign result.had_samples   = res_had_reg;
    assign result.last_of_round = res_last_reg;

endmodule
